// File: sv/orfc_pkg.sv
// ----------------------------------------------------------------------------
// orfc_pkg
// Types and constants of the obstacle repulsion field cost block.
// ----------------------------------------------------------------------------
package orfc_pkg;

  localparam int OBJ_MAX_DEF = 16;

  localparam logic [47:0] SUM_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [39:0] COST_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [15:0] CNT_MAX  = 16'hFFFF;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  localparam logic REG_STEP  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_MOD, S_RD, S_DIFF, S_M1, S_M2, S_D2, S_SQ, S_DA, S_DC, S_NXT,
    S_ABS, S_NORM, S_MM1, S_MM2, S_MSUM, S_MSQ, S_MADD, S_FDIV1, S_FDIV2, S_OUT
  } state_t;

endpackage

// File: sv/obstacle_repulsion_field_cost.sv
// ----------------------------------------------------------------------------
// obstacle_repulsion_field_cost
// Repulsion cost of a path against a table of stationary obstacles.
// ----------------------------------------------------------------------------
// A load (operation 0) writes one obstacle entry while busy stays low. A path
// point first needs a modulo on the shared divide/square-root unit (a start,
// 64 steps and a finish). A sampled point then walks the in-use obstacles,
// each with one 32 step root and four 64 step divides (each with its start
// and finish) plus datapath states, and then the magnitude follows, with a
// square root on the unit. The final point takes one or two 64 step divides.
// The unit is the only path to the result. The cost appears on path_cost and
// degenerate for one cycle with done high; there is no way to hold it, so
// the receiver must take it in that cycle.
module obstacle_repulsion_field_cost #(
  parameter int OBJ_MAX = orfc_pkg::OBJ_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic [3:0]         object_slot,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic               end_of_path,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               done,
  output logic [39:0]        path_cost,
  output logic               degenerate
);

  localparam int IW = (OBJ_MAX > 1) ? $clog2(OBJ_MAX) : 1;
  localparam int CW = $clog2(OBJ_MAX + 1);

  orfc_pkg::state_t state, state_next;

  // configuration
  logic [7:0]  sample_step;
  logic [4:0]  object_count;
  logic [7:0]  step_eff;
  logic [CW-1:0] n_use;

  // path state
  logic [15:0] point_counter;
  logic [47:0] magnitude_sum;
  logic        fault_seen;

  // work registers
  logic signed [23:0] px, py;
  logic [47:0]   obj_mem [OBJ_MAX];
  logic [47:0]   rd_q;
  logic [CW-1:0] idx;
  logic [23:0]   ax, ay;
  logic          sgnx, sgny, comp_y;
  logic [63:0]   p1, p2;
  logic [48:0]   d2;
  logic [31:0]   q, root;
  logic [39:0]   a_reg, qt;
  logic signed [47:0] sx, sy;
  logic [47:0]   mx, my;
  logic [4:0]    k;
  logic [63:0]   msum;
  logic [16:0]   divq;
  logic          fbad;

  // shared divide / square-root unit
  logic        u_go, u_busy, u_fin, u_sqrt, u_op_sqrt;
  logic [5:0]  u_cnt;
  logic [63:0] u_work, u_res, u_rem, u_dsr, u_op_a, u_op_b;
  logic [64:0] u_rs, u_trial, u_diff;
  logic        u_ge;

  logic        accept;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic signed [24:0] rx_s, ry_s;
  logic [48:0] d2_sum;
  logic [47:0] mag;
  logic [48:0] sum_ext;
  logic signed [47:0] cpart;

  assign accept   = start && !busy;
  assign step_eff = (sample_step == 8'd0) ? 8'd1 : sample_step;
  assign n_use    = (32'(object_count) > OBJ_MAX) ? CW'(OBJ_MAX) : CW'(object_count);

  // ---------------- shared unit ----------------
  always_comb begin
    if (u_sqrt) begin
      u_rs    = {u_rem[62:0], u_work[63:62]};
      u_trial = {1'b0, u_res[61:0], 2'b01};
    end else begin
      u_rs    = {u_rem, u_work[63]};
      u_trial = {1'b0, u_dsr};
    end
    u_ge   = (u_rs >= u_trial);
    u_diff = u_rs - u_trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_busy <= 1'b0;
      u_fin  <= 1'b0;
    end else begin
      u_fin <= 1'b0;
      if (u_go) begin
        u_busy <= 1'b1;
        u_sqrt <= u_op_sqrt;
        u_cnt  <= u_op_sqrt ? 6'd31 : 6'd63;
        u_work <= u_op_a;
        u_dsr  <= u_op_b;
        u_res  <= '0;
        u_rem  <= '0;
      end else if (u_busy) begin
        u_rem  <= u_ge ? u_diff[63:0] : u_rs[63:0];
        u_res  <= {u_res[62:0], u_ge};
        u_work <= u_sqrt ? {u_work[61:0], 2'b00} : {u_work[62:0], 1'b0};
        u_cnt  <= u_cnt - 6'd1;
        if (u_cnt == 6'd0) begin
          u_busy <= 1'b0;
          u_fin  <= 1'b1;
        end
      end
    end
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    unique case (state)
      orfc_pkg::S_M1:  begin mul_a = 32'(ax); mul_b = 32'(ax); end
      orfc_pkg::S_M2:  begin mul_a = 32'(ay); mul_b = 32'(ay); end
      orfc_pkg::S_MM1: begin mul_a = mx[31:0]; mul_b = mx[31:0]; end
      orfc_pkg::S_MM2: begin mul_a = my[31:0]; mul_b = my[31:0]; end
      default:         begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign rx_s   = {rd_q[47], rd_q[47:24]} - {px[23], px};
  assign ry_s   = {rd_q[23], rd_q[23:0]} - {py[23], py};
  assign d2_sum = {1'b0, p1[47:0]} + {1'b0, p2[47:0]};
  assign mag    = 48'({16'd0, root} << k);
  assign sum_ext = {1'b0, magnitude_sum} + {1'b0, mag};
  assign cpart  = (comp_y ? sgny : sgnx) ? -48'(u_res[33:0]) : 48'(u_res[33:0]);

  // ---------------- obstacle table ----------------
  always_ff @(posedge clk) begin
    if (accept && operation == orfc_pkg::OP_LOAD && 32'(object_slot) < OBJ_MAX) begin
      obj_mem[IW'(object_slot)] <= {pos_x, pos_y};
    end
    rd_q <= obj_mem[idx[IW-1:0]];
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      orfc_pkg::S_IDLE: begin
        if (accept && operation == orfc_pkg::OP_POINT) begin
          if (end_of_path) state_next = orfc_pkg::S_FDIV1;
          else if (point_counter != orfc_pkg::CNT_MAX) state_next = orfc_pkg::S_MOD;
        end
      end
      orfc_pkg::S_MOD: begin
        if (u_fin) begin
          if (u_rem != 64'd0) state_next = orfc_pkg::S_IDLE;
          else if (n_use == '0) state_next = orfc_pkg::S_ABS;
          else state_next = orfc_pkg::S_RD;
        end
      end
      orfc_pkg::S_RD:   state_next = orfc_pkg::S_DIFF;
      orfc_pkg::S_DIFF: state_next = orfc_pkg::S_M1;
      orfc_pkg::S_M1:   state_next = orfc_pkg::S_M2;
      orfc_pkg::S_M2:   state_next = orfc_pkg::S_D2;
      orfc_pkg::S_D2:   state_next = (d2_sum == '0) ? orfc_pkg::S_NXT : orfc_pkg::S_SQ;
      orfc_pkg::S_SQ:   if (u_fin) state_next = orfc_pkg::S_DA;
      orfc_pkg::S_DA:   if (u_fin) state_next = orfc_pkg::S_DC;
      orfc_pkg::S_DC: begin
        if (u_fin) state_next = comp_y ? orfc_pkg::S_NXT : orfc_pkg::S_DA;
      end
      orfc_pkg::S_NXT: begin
        state_next = (idx + CW'(1) == n_use) ? orfc_pkg::S_ABS : orfc_pkg::S_RD;
      end
      orfc_pkg::S_ABS:  state_next = orfc_pkg::S_NORM;
      orfc_pkg::S_NORM: begin
        if (!((|mx[47:31]) || (|my[47:31]))) state_next = orfc_pkg::S_MM1;
      end
      orfc_pkg::S_MM1:  state_next = orfc_pkg::S_MM2;
      orfc_pkg::S_MM2:  state_next = orfc_pkg::S_MSUM;
      orfc_pkg::S_MSUM: state_next = orfc_pkg::S_MSQ;
      orfc_pkg::S_MSQ:  if (u_fin) state_next = orfc_pkg::S_MADD;
      orfc_pkg::S_MADD: state_next = orfc_pkg::S_IDLE;
      orfc_pkg::S_FDIV1: begin
        if (u_fin) begin
          state_next = (fault_seen || u_res == 64'd0) ? orfc_pkg::S_OUT : orfc_pkg::S_FDIV2;
        end
      end
      orfc_pkg::S_FDIV2: if (u_fin) state_next = orfc_pkg::S_OUT;
      orfc_pkg::S_OUT:   state_next = orfc_pkg::S_IDLE;
      default:           state_next = orfc_pkg::S_IDLE;
    endcase
  end

  // unit requests and operands
  always_comb begin
    u_op_a    = '0;
    u_op_b    = '0;
    u_op_sqrt = 1'b0;
    u_go      = 1'b0;
    unique case (state)
      orfc_pkg::S_MOD: begin
        u_op_a = 64'(point_counter);
        u_op_b = 64'(step_eff);
        u_go   = !u_busy && !u_fin;
      end
      orfc_pkg::S_SQ: begin
        u_op_a    = 64'({d2, 14'd0});
        u_op_sqrt = 1'b1;
        u_go      = !u_busy && !u_fin;
      end
      orfc_pkg::S_DA: begin
        u_op_a = 64'({(comp_y ? ay : ax), 38'd0});
        u_op_b = 64'(d2);
        u_go   = !u_busy && !u_fin;
      end
      orfc_pkg::S_DC: begin
        u_op_a = 64'({a_reg, 1'b0});
        u_op_b = 64'(q);
        u_go   = !u_busy && !u_fin;
      end
      orfc_pkg::S_MSQ: begin
        u_op_a    = msum;
        u_op_sqrt = 1'b1;
        u_go      = !u_busy && !u_fin;
      end
      orfc_pkg::S_FDIV1: begin
        u_op_a = 64'({1'b0, point_counter} + 17'd1);
        u_op_b = 64'(step_eff);
        u_go   = !u_busy && !u_fin;
      end
      orfc_pkg::S_FDIV2: begin
        u_op_a = 64'(magnitude_sum);
        u_op_b = 64'(divq);
        u_go   = !u_busy && !u_fin;
      end
      default: u_go = 1'b0;
    endcase
  end

  assign busy = (state != orfc_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= orfc_pkg::S_IDLE;
    else     state <= state_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_step  <= 8'd1;
      object_count <= 5'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        orfc_pkg::REG_STEP:  sample_step  <= cfg_data;
        orfc_pkg::REG_COUNT: object_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // path state and result
  always_ff @(posedge clk) begin
    if (rst) begin
      point_counter <= '0;
      magnitude_sum <= '0;
      fault_seen    <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        orfc_pkg::S_IDLE: begin
          if (accept && operation == orfc_pkg::OP_POINT && !end_of_path
              && point_counter == orfc_pkg::CNT_MAX) begin
            fault_seen <= 1'b1;
          end
        end
        orfc_pkg::S_MOD: begin
          if (u_fin && u_rem != 64'd0) point_counter <= point_counter + 16'd1;
        end
        orfc_pkg::S_D2: if (d2_sum == '0) fault_seen <= 1'b1;
        orfc_pkg::S_MADD: begin
          point_counter <= point_counter + 16'd1;
          if (sum_ext[48]) begin
            magnitude_sum <= orfc_pkg::SUM_MAX;
            fault_seen    <= 1'b1;
          end else begin
            magnitude_sum <= sum_ext[47:0];
          end
        end
        orfc_pkg::S_OUT: begin
          done          <= 1'b1;
          path_cost     <= fbad ? orfc_pkg::COST_MAX : qt;
          degenerate    <= fbad;
          point_counter <= '0;
          magnitude_sum <= '0;
          fault_seen    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // evaluation datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      px <= pos_x;
      py <= pos_y;
    end
    unique case (state)
      orfc_pkg::S_MOD: begin
        idx    <= '0;
        sx     <= '0;
        sy     <= '0;
        comp_y <= 1'b0;
      end
      orfc_pkg::S_DIFF: begin
        sgnx <= rx_s[24];
        sgny <= ry_s[24];
        ax   <= rx_s[24] ? 24'(-rx_s) : rx_s[23:0];
        ay   <= ry_s[24] ? 24'(-ry_s) : ry_s[23:0];
        comp_y <= 1'b0;
      end
      orfc_pkg::S_M1, orfc_pkg::S_MM1: p1 <= prod;
      orfc_pkg::S_M2, orfc_pkg::S_MM2: p2 <= prod;
      orfc_pkg::S_D2:  d2 <= d2_sum;
      orfc_pkg::S_SQ:  if (u_fin) q <= u_res[31:0];
      orfc_pkg::S_DA:  if (u_fin) a_reg <= u_res[39:0];
      orfc_pkg::S_DC: begin
        if (u_fin) begin
          if (comp_y) sy <= sy + cpart;
          else        sx <= sx + cpart;
          comp_y <= 1'b1;
        end
      end
      orfc_pkg::S_NXT: idx <= idx + CW'(1);
      orfc_pkg::S_ABS: begin
        mx <= sx[47] ? 48'(-sx) : 48'(sx);
        my <= sy[47] ? 48'(-sy) : 48'(sy);
        k  <= '0;
      end
      orfc_pkg::S_NORM: begin
        // scale both parts down until each fits in 31 bits
        if ((|mx[47:31]) || (|my[47:31])) begin
          mx <= mx >> 1;
          my <= my >> 1;
          k  <= k + 5'd1;
        end
      end
      orfc_pkg::S_MSUM: msum <= p1 + p2;
      orfc_pkg::S_MSQ:  if (u_fin) root <= u_res[31:0];
      orfc_pkg::S_FDIV1: begin
        if (u_fin) begin
          divq <= u_res[16:0];
          fbad <= fault_seen || u_res == 64'd0;
        end
      end
      orfc_pkg::S_FDIV2: begin
        if (u_fin) begin
          qt   <= u_res[39:0];
          fbad <= |u_res[63:40];
        end
      end
      default: ;
    endcase
  end

  // ---------------- assertions ----------------
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == orfc_pkg::S_OUT))
    else $error("done without a final divide");

  a_fin_after_run: assert property (@(posedge clk) disable iff (rst)
    u_fin |-> $past(u_busy))
    else $error("unit finished without running");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == orfc_pkg::OP_LOAD) |=> !busy)
    else $error("load made the block busy");

  a_done_clear: assert property (@(posedge clk) disable iff (rst)
    done |-> (point_counter == '0 && magnitude_sum == '0 && !fault_seen))
    else $error("path state not cleared after result");

  a_go_idle_unit: assert property (@(posedge clk) disable iff (rst)
    u_go |-> !u_busy)
    else $error("unit restarted while running");

endmodule

// File: verif/obstacle_repulsion_field_cost_tb.sv
// ----------------------------------------------------------------------------
// obstacle_repulsion_field_cost_tb
// Self-checking bench: loads obstacle tables, streams paths of points under
// several stride and table-size settings, predicts or types every path cost
// (prediction in 64-bit integer arithmetic) and compares each done word to it.
// ----------------------------------------------------------------------------
module obstacle_repulsion_field_cost_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NUM_ITEMS   = 1250;
  localparam longint CYC_LIMIT = 30_000_000;
  localparam logic signed [23:0] C_MAX = 24'sh7F_FFFF;
  localparam logic signed [23:0] C_MIN = -24'sh80_0000;

  typedef struct {
    logic [39:0] cost;
    logic        degen;
  } cost_word_t;

  typedef struct {
    logic              cfg_on;
    logic              cfg_idx;
    logic [7:0]        cfg_val;
    logic              op;
    logic [3:0]        slot;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic              last;
    logic              known;
    logic [39:0]       cost;
    logic              degen;
  } stim_row_t;

  logic clk, rst, start, busy, operation, end_of_path;
  logic [3:0] object_slot;
  logic signed [23:0] pos_x, pos_y;
  logic cfg_we, cfg_index;
  logic [7:0] cfg_data;
  logic done, degenerate;
  logic [39:0] path_cost;

  obstacle_repulsion_field_cost i_dut (.*);

  // predictor state
  logic signed [23:0] obs_x [16];
  logic signed [23:0] obs_y [16];
  logic [15:0] pt_cnt;
  logic [63:0] mag_acc;
  logic        fault;
  logic [7:0]  stride;
  logic [4:0]  n_obs;

  cost_word_t cost_q[$];
  int errors = 0;
  int sent = 0;
  longint cycles = 0;

  stim_row_t dir_tab [16] = '{
    '{1'b0, orfc_pkg::REG_STEP,  8'd0,   orfc_pkg::OP_POINT, 4'd0, 24'sd0, 24'sd0,
      1'b1, 1'b1, 40'd0, 1'b0},
    '{1'b1, orfc_pkg::REG_COUNT, 8'd3,   orfc_pkg::OP_POINT, 4'd0, 24'sd0, 24'sd0,
      1'b0, 1'b0, 40'd0, 1'b0},
    '{1'b0, orfc_pkg::REG_STEP,  8'd0,   orfc_pkg::OP_POINT, 4'd0, 24'sd256, 24'sd256,
      1'b1, 1'b1, orfc_pkg::COST_MAX, 1'b1},
    '{1'b0, orfc_pkg::REG_STEP,  8'd0,   orfc_pkg::OP_POINT, 4'd0, C_MAX, C_MAX,
      1'b0, 1'b0, 40'd0, 1'b0},
    '{1'b0, orfc_pkg::REG_STEP,  8'd0,   orfc_pkg::OP_POINT, 4'd0, C_MIN, C_MIN,
      1'b1, 1'b0, 40'd0, 1'b0},
    '{1'b1, orfc_pkg::REG_STEP,  8'd255, orfc_pkg::OP_POINT, 4'd0, 24'sd5, 24'sd5,
      1'b0, 1'b0, 40'd0, 1'b0},
    '{1'b0, orfc_pkg::REG_STEP,  8'd0,   orfc_pkg::OP_POINT, 4'd0, 24'sd7, 24'sd7,
      1'b1, 1'b1, orfc_pkg::COST_MAX, 1'b1},
    '{1'b1, orfc_pkg::REG_STEP,  8'd0,   orfc_pkg::OP_POINT, 4'd0, -24'sd3000, 24'sd1200,
      1'b0, 1'b0, 40'd0, 1'b0},
    '{1'b0, orfc_pkg::REG_STEP,  8'd0,   orfc_pkg::OP_POINT, 4'd0, 24'sd0, 24'sd0,
      1'b1, 1'b0, 40'd0, 1'b0},
    '{1'b1, orfc_pkg::REG_COUNT, 8'd31,  orfc_pkg::OP_POINT, 4'd0, 24'sd100, -24'sd100,
      1'b0, 1'b0, 40'd0, 1'b0},
    // table rewrite in the middle of a path
    '{1'b0, orfc_pkg::REG_STEP,  8'd0,   orfc_pkg::OP_LOAD,  4'd3, 24'sd1024, -24'sd1024,
      1'b0, 1'b0, 40'd0, 1'b0},
    '{1'b0, orfc_pkg::REG_STEP,  8'd0,   orfc_pkg::OP_POINT, 4'd0, -24'sd100, 24'sd100,
      1'b0, 1'b0, 40'd0, 1'b0},
    '{1'b0, orfc_pkg::REG_STEP,  8'd0,   orfc_pkg::OP_POINT, 4'd0, 24'sd9, 24'sd9,
      1'b1, 1'b0, 40'd0, 1'b0},
    '{1'b1, orfc_pkg::REG_COUNT, 8'd16,  orfc_pkg::OP_POINT, 4'd0, 24'sd1, 24'sd1,
      1'b0, 1'b0, 40'd0, 1'b0},
    '{1'b0, orfc_pkg::REG_STEP,  8'd0,   orfc_pkg::OP_POINT, 4'd0, -24'sd1, 24'sd2,
      1'b0, 1'b0, 40'd0, 1'b0},
    '{1'b0, orfc_pkg::REG_STEP,  8'd0,   orfc_pkg::OP_POINT, 4'd0, 24'sd40000, -24'sd40000,
      1'b1, 1'b0, 40'd0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // field strength at one point, added into the running magnitude sum
  function automatic void field_at_point(input logic signed [23:0] px,
                                         input logic signed [23:0] py);
    longint sx, sy, rx, ry;
    logic [63:0] ax, ay, d2, q, cx, cy, mx, my, mag;
    int n, k;
    n = (n_obs > 16) ? 16 : int'(n_obs);
    sx = 0;
    sy = 0;
    for (int i = 0; i < n; i++) begin
      rx = longint'(obs_x[i]) - longint'(px);
      ry = longint'(obs_y[i]) - longint'(py);
      ax = (rx < 0) ? -rx : rx;
      ay = (ry < 0) ? -ry : ry;
      d2 = ax * ax + ay * ay;
      if (d2 == 0) begin
        fault = 1'b1;
        continue;
      end
      q  = int_root(d2 << 14);
      cx = (((ax << 38) / d2) << 1) / q;
      cy = (((ay << 38) / d2) << 1) / q;
      sx += (rx < 0) ? -longint'(cx) : longint'(cx);
      sy += (ry < 0) ? -longint'(cy) : longint'(cy);
    end
    mx = (sx < 0) ? -sx : sx;
    my = (sy < 0) ? -sy : sy;
    k = 0;
    while ((mx >> k) >= (64'd1 << 31) || (my >> k) >= (64'd1 << 31)) k++;
    mx = mx >> k;
    my = my >> k;
    mag = int_root(mx * mx + my * my) << k;
    if (mag > {16'd0, orfc_pkg::SUM_MAX} - mag_acc) begin
      mag_acc = {16'd0, orfc_pkg::SUM_MAX};
      fault = 1'b1;
    end else begin
      mag_acc = mag_acc + mag;
    end
  endfunction

  // returns 1 and the cost word when the item closes a path
  function automatic bit predict_cost(input logic op, input logic [3:0] slot,
                                      input logic signed [23:0] px,
                                      input logic signed [23:0] py,
                                      input logic last, output cost_word_t w);
    int step;
    int unsigned div;
    logic [63:0] qt;
    step = (stride == 0) ? 1 : int'(stride);
    if (op == orfc_pkg::OP_LOAD) begin
      obs_x[slot] = px;
      obs_y[slot] = py;
      return 0;
    end
    if (!last) begin
      if (pt_cnt >= orfc_pkg::CNT_MAX) begin
        fault = 1'b1;
      end else begin
        if (int'(pt_cnt) % step == 0) field_at_point(px, py);
        pt_cnt = pt_cnt + 16'd1;
      end
      return 0;
    end
    div = (int'(pt_cnt) + 1) / step;
    w.cost = orfc_pkg::COST_MAX;
    w.degen = 1'b1;
    if (!fault && div != 0) begin
      qt = mag_acc / div;
      if (qt <= {24'd0, orfc_pkg::COST_MAX}) begin
        w.cost = qt[39:0];
        w.degen = 1'b0;
      end
    end
    pt_cnt = '0;
    mag_acc = '0;
    fault = 1'b0;
    return 1;
  endfunction

  task automatic wait_idle();
    start <= 1'b0;
    while (cost_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == orfc_pkg::REG_STEP) stride = val;
    else n_obs = val[4:0];
  endtask

  // one input word; a typed expectation overrides the predicted one
  task automatic send_word(input logic op, input logic [3:0] slot,
                           input logic signed [23:0] px,
                           input logic signed [23:0] py, input logic last,
                           input logic known, input cost_word_t typed);
    int gap;
    cost_word_t w;
    gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 14));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    object_slot <= slot;
    pos_x <= px;
    pos_y <= py;
    end_of_path <= last;
    do @(posedge clk); while (busy);
    sent++;
    if (predict_cost(op, slot, px, py, last, w)) cost_q.push_back(known ? typed : w);
  endtask

  always @(posedge clk) begin
    cost_word_t e;
    cycles <= cycles + 1;
    if (cycles >= CYC_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst && done) begin
      if (cost_q.size() == 0) begin
        $error("unexpected cost word: path_cost %0d degenerate %0d", path_cost, degenerate);
        errors++;
      end else begin
        e = cost_q.pop_front();
        if (path_cost !== e.cost) begin
          $error("path_cost expected %0d actual %0d", e.cost, path_cost);
          errors++;
        end
        if (degenerate !== e.degen) begin
          $error("degenerate expected %0d actual %0d", e.degen, degenerate);
          errors++;
        end
      end
    end
  end

  initial begin
    cost_word_t none;
    logic [3:0] s;
    logic signed [23:0] px, py;
    int plen, lim;
    bit near;
    none = '{40'd0, 1'b0};
    rst = 1'b1;
    start = 1'b0;
    operation = orfc_pkg::OP_LOAD;
    object_slot = '0;
    pos_x = '0;
    pos_y = '0;
    end_of_path = 1'b0;
    cfg_we = 1'b0;
    cfg_index = orfc_pkg::REG_STEP;
    cfg_data = '0;
    for (int i = 0; i < 16; i++) begin
      obs_x[i] = '0;
      obs_y[i] = '0;
    end
    pt_cnt = '0;
    mag_acc = '0;
    fault = 1'b0;
    stride = 8'd1;
    n_obs = 5'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole table so no later setting reads an unwritten entry
    for (int i = 0; i < 16; i++) begin
      case (i)
        0: begin px = C_MAX; py = C_MIN; end
        1: begin px = C_MIN; py = C_MAX; end
        2: begin px = 24'sd0; py = 24'sd0; end
        default: begin
          px = 24'(int'($urandom_range(0, 8191)) - 4096);
          py = 24'($urandom());
        end
      endcase
      send_word(orfc_pkg::OP_LOAD, i[3:0], px, py, 1'b0, 1'b0, none);
    end

    foreach (dir_tab[r]) begin
      if (dir_tab[r].cfg_on) write_reg(dir_tab[r].cfg_idx, dir_tab[r].cfg_val);
      send_word(dir_tab[r].op, dir_tab[r].slot, dir_tab[r].x, dir_tab[r].y,
                dir_tab[r].last, dir_tab[r].known, '{dir_tab[r].cost, dir_tab[r].degen});
    end

    while (sent < NUM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: write_reg(orfc_pkg::REG_STEP, 8'd1);
        1: write_reg(orfc_pkg::REG_STEP, 8'd255);
        2: write_reg(orfc_pkg::REG_STEP, 8'd0);
        default: write_reg(orfc_pkg::REG_STEP, 8'($urandom_range(1, 6)));
      endcase
      case ($urandom_range(0, 11))
        0: write_reg(orfc_pkg::REG_COUNT, 8'd16);
        1: write_reg(orfc_pkg::REG_COUNT, 8'($urandom_range(17, 31)));
        default: write_reg(orfc_pkg::REG_COUNT, 8'($urandom_range(0, 4)));
      endcase
      lim = (n_obs > 4) ? 2 : 6;
      for (int p = 0; p < lim && sent < NUM_ITEMS; p++) begin
        plen = int'($urandom_range(0, 12));
        for (int j = 0; j <= plen; j++) begin
          if ($urandom_range(0, 9) == 0) begin
            s = 4'($urandom());
            send_word(orfc_pkg::OP_LOAD, s, 24'($urandom()), 24'($urandom()),
                      1'($urandom_range(0, 1)), 1'b0, none);
          end
          near = ($urandom_range(0, 2) != 0);
          s = 4'($urandom_range(0, 15));
          px = near ? 24'(int'(obs_x[s]) + int'($urandom_range(0, 64)) - 32)
                    : 24'($urandom());
          py = near ? 24'(int'(obs_y[s]) + int'($urandom_range(0, 64)) - 32)
                    : 24'($urandom());
          send_word(orfc_pkg::OP_POINT, 4'($urandom()), px, py, j == plen, 1'b0, none);
        end
      end
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0 && cost_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
